@@ hdl/stsc_pkg.sv @@
package stsc_pkg;

  // Token kind codes
  typedef logic [5:0] kind_t;

  localparam kind_t K_END    = 6'd0;
  localparam kind_t K_ERR    = 6'd1;
  localparam kind_t K_ID     = 6'd2;
  localparam kind_t K_INT    = 6'd3;
  localparam kind_t K_REAL   = 6'd4;
  localparam kind_t K_KW0    = 6'd5;
  localparam kind_t K_DOT    = 6'd17;
  localparam kind_t K_COMMA  = 6'd18;
  localparam kind_t K_SEMI   = 6'd19;
  localparam kind_t K_COLON  = 6'd20;
  localparam kind_t K_LPAREN = 6'd21;
  localparam kind_t K_RPAREN = 6'd22;
  localparam kind_t K_LBRACE = 6'd23;
  localparam kind_t K_RBRACE = 6'd24;
  localparam kind_t K_PCT    = 6'd25;
  localparam kind_t K_SLASH  = 6'd26;
  localparam kind_t K_STAR   = 6'd27;
  localparam kind_t K_MINUS  = 6'd28;
  localparam kind_t K_PLUS   = 6'd29;
  localparam kind_t K_EQEQ   = 6'd30;
  localparam kind_t K_ASSIGN = 6'd31;
  localparam kind_t K_OROR   = 6'd32;
  localparam kind_t K_ANDAND = 6'd33;
  localparam kind_t K_NE     = 6'd34;
  localparam kind_t K_NOT    = 6'd35;
  localparam kind_t K_LE     = 6'd36;
  localparam kind_t K_LT     = 6'd37;
  localparam kind_t K_GE     = 6'd38;
  localparam kind_t K_GT     = 6'd39;

  // Configuration register indexes
  localparam logic [7:0] REG_IDENT_LIMIT = 8'd0;
  localparam logic [7:0] REG_INT_LIMIT   = 8'd1;
  localparam logic [7:0] REG_REAL_LIMIT  = 8'd2;

  // Keyword buffer: first characters of the current identifier
  localparam int KW_CHARS = 8;
  localparam int KW_IDX_W = $clog2(KW_CHARS);
  localparam int KW_COUNT = 12;

  typedef logic [KW_CHARS-1:0][7:0] word_t;

  localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
    '{"c", "o", "n", "s", "t", 8'h0, 8'h0, 8'h0},
    '{"s", "h", "o", "r", "t", 8'h0, 8'h0, 8'h0},
    '{"l", "o", "n", "g", 8'h0, 8'h0, 8'h0, 8'h0},
    '{"i", "n", "t", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
    '{"d", "o", "u", "b", "l", "e", 8'h0, 8'h0},
    '{"s", "w", "i", "t", "c", "h", 8'h0, 8'h0},
    '{"c", "a", "s", "e", 8'h0, 8'h0, 8'h0, 8'h0},
    '{"b", "r", "e", "a", "k", 8'h0, 8'h0, 8'h0},
    '{"d", "e", "f", "a", "u", "l", "t", 8'h0},
    '{"r", "e", "t", "u", "r", "n", 8'h0, 8'h0},
    '{"c", "l", "a", "s", "s", 8'h0, 8'h0, 8'h0},
    '{"m", "a", "i", "n", 8'h0, 8'h0, 8'h0, 8'h0}
  };

  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd5, 4'd5, 4'd4, 4'd3, 4'd6, 4'd6, 4'd4, 4'd5, 4'd7, 4'd6, 4'd5, 4'd4
  };

  // Result queue depth; two words may enter per cycle
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCOUNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0] ident_limit;
    logic [7:0] int_limit;
    logic [7:0] real_limit;
  } limits_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  length;
    logic [15:0] line;
    logic        last;
  } token_t;

  typedef struct packed {
    logic [1:0] n;
    token_t     tok0;
    token_t     tok1;
  } push_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  // Keyword lookup over the buffered characters; identifier if none match
  function automatic kind_t kw_kind(input word_t w, input logic [7:0] len);
    kind_t k;
    logic  hit;
    k = K_ID;
    for (int i = 0; i < KW_COUNT; i++) begin
      hit = (len == {4'd0, KW_LEN[i]});
      for (int j = 0; j < KW_CHARS; j++) begin
        if ((j < int'(KW_LEN[i])) && (w[j] != KW_TEXT[i][j])) hit = 1'b0;
      end
      if (hit && (k == K_ID)) k = K_KW0 + 6'(i);
    end
    return k;
  endfunction

endpackage

@@ hdl/stsc_scan.sv @@
module stsc_scan import stsc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] ch,
  input  limits_t    lim,
  output push_t      push
);

  localparam logic [3:0] M_IDLE     = 4'd0;
  localparam logic [3:0] M_COMMENT  = 4'd1;
  localparam logic [3:0] M_SLASH    = 4'd2;
  localparam logic [3:0] M_IDENT    = 4'd3;
  localparam logic [3:0] M_INT      = 4'd4;
  localparam logic [3:0] M_DOT      = 4'd5;
  localparam logic [3:0] M_FRAC     = 4'd6;
  localparam logic [3:0] M_EXPSTART = 4'd7;
  localparam logic [3:0] M_EXPSIGN  = 4'd8;
  localparam logic [3:0] M_EXPDIG   = 4'd9;
  localparam logic [3:0] M_EQ       = 4'd10;
  localparam logic [3:0] M_BANG     = 4'd11;
  localparam logic [3:0] M_LESS     = 4'd12;
  localparam logic [3:0] M_MORE     = 4'd13;
  localparam logic [3:0] M_BAR      = 4'd14;
  localparam logic [3:0] M_AMP      = 4'd15;

  localparam logic [7:0] CH_EOT = 8'h00;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_NL  = 8'h0A;
  localparam logic [7:0] CH_SP  = 8'h20;

  logic [3:0]  mode_r, mode_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [15:0] line_r, line_nxt;
  word_t       word_r;

  logic        wr_en;
  logic [KW_IDX_W-1:0] wr_idx;

  logic        taken, p_emit, i_emit;
  kind_t       p_kind, i_kind;
  logic [7:0]  p_len, i_len, len_inc;
  logic        exp_ch, sign_ch;
  token_t      tok_p, tok_i;

  // Length reaches limit minus one; limits 0 and 1 always hit
  function automatic logic at_limit(input logic [7:0] len, input logic [7:0] lim_v);
    return ({1'b0, len} + 9'd1) >= {1'b0, lim_v};
  endfunction

  assign len_inc = (len_r == 8'hFF) ? len_r : len_r + 8'd1;
  assign exp_ch  = (ch == "E") || (ch == "e");
  assign sign_ch = (ch == "+") || (ch == "-");

  // Finish or extend the pending token, then rescan a character it did not take
  always_comb begin
    taken    = 1'b0;
    p_emit   = 1'b0;
    p_kind   = K_END;
    p_len    = len_r;
    i_emit   = 1'b0;
    i_kind   = K_END;
    i_len    = 8'd1;
    mode_nxt = mode_r;
    len_nxt  = len_r;
    line_nxt = line_r;
    wr_en    = 1'b0;
    wr_idx   = len_r[KW_IDX_W-1:0];

    unique case (mode_r)
      M_IDLE: taken = 1'b0;
      M_COMMENT: taken = !((ch == CH_NL) || (ch == CH_EOT));
      M_SLASH: begin
        if (ch == "/") begin
          taken = 1'b1; mode_nxt = M_COMMENT;
        end else begin
          p_emit = 1'b1; p_kind = K_SLASH; p_len = 8'd1;
        end
      end
      M_IDENT: begin
        if (is_digit(ch) || is_letter(ch) || (ch == "_")) begin
          taken = 1'b1;
          wr_en = (len_r < 8'(KW_CHARS));
          len_nxt = len_inc;
        end else begin
          p_emit = 1'b1;
          p_kind = at_limit(len_r, lim.ident_limit) ? K_ERR : kw_kind(word_r, len_r);
        end
      end
      M_INT: begin
        if (is_digit(ch)) begin
          taken = 1'b1; len_nxt = len_inc;
        end else if (at_limit(len_r, lim.int_limit)) begin
          p_emit = 1'b1; p_kind = K_ERR;
        end else if (ch == ".") begin
          taken = 1'b1; len_nxt = len_inc; mode_nxt = M_FRAC;
        end else if (exp_ch) begin
          taken = 1'b1; len_nxt = len_inc; mode_nxt = M_EXPSTART;
        end else begin
          p_emit = 1'b1; p_kind = K_INT;
        end
      end
      M_DOT: begin
        if (is_digit(ch)) begin
          taken = 1'b1; len_nxt = len_inc; mode_nxt = M_FRAC;
        end else begin
          p_emit = 1'b1; p_kind = K_DOT; p_len = 8'd1;
        end
      end
      M_FRAC: begin
        if (is_digit(ch)) begin
          taken = 1'b1; len_nxt = len_inc;
        end else if (!at_limit(len_r, lim.real_limit) && exp_ch) begin
          taken = 1'b1; len_nxt = len_inc; mode_nxt = M_EXPSTART;
        end else begin
          p_emit = 1'b1; p_kind = K_ERR;
        end
      end
      M_EXPSTART: begin
        if (sign_ch) begin
          taken = 1'b1; len_nxt = len_inc; mode_nxt = M_EXPSIGN;
        end else if (is_digit(ch)) begin
          taken = 1'b1; len_nxt = len_inc; mode_nxt = M_EXPDIG;
        end else begin
          p_emit = 1'b1; p_kind = K_ERR;
        end
      end
      M_EXPSIGN: begin
        if (is_digit(ch)) begin
          taken = 1'b1; len_nxt = len_inc;
          // check the limit on the first signed exponent digit
          if (at_limit(len_inc, lim.real_limit)) begin
            p_emit = 1'b1; p_kind = K_ERR; p_len = len_inc; mode_nxt = M_IDLE;
          end else begin
            mode_nxt = M_EXPDIG;
          end
        end else begin
          p_emit = 1'b1; p_kind = K_ERR;
        end
      end
      M_EXPDIG: begin
        if (is_digit(ch)) begin
          taken = 1'b1; len_nxt = len_inc;
        end else begin
          p_emit = 1'b1;
          p_kind = at_limit(len_r, lim.real_limit) ? K_ERR : K_REAL;
        end
      end
      M_EQ, M_BANG, M_LESS, M_MORE: begin
        p_emit = 1'b1;
        if (ch == "=") begin
          taken = 1'b1; mode_nxt = M_IDLE; p_len = 8'd2;
          case (mode_r)
            M_EQ:    p_kind = K_EQEQ;
            M_BANG:  p_kind = K_NE;
            M_LESS:  p_kind = K_LE;
            default: p_kind = K_GE;
          endcase
        end else begin
          p_len = 8'd1;
          case (mode_r)
            M_EQ:    p_kind = K_ASSIGN;
            M_BANG:  p_kind = K_NOT;
            M_LESS:  p_kind = K_LT;
            default: p_kind = K_GT;
          endcase
        end
      end
      M_BAR: begin
        p_emit = 1'b1;
        if (ch == "|") begin
          taken = 1'b1; mode_nxt = M_IDLE; p_kind = K_OROR; p_len = 8'd2;
        end else begin
          p_kind = K_ERR; p_len = 8'd1;
        end
      end
      M_AMP: begin
        p_emit = 1'b1;
        if (ch == "&") begin
          taken = 1'b1; mode_nxt = M_IDLE; p_kind = K_ANDAND; p_len = 8'd2;
        end else begin
          p_kind = K_ERR; p_len = 8'd1;
        end
      end
      default: taken = 1'b0;
    endcase

    // Scan the character from idle: skip blanks, count lines, start tokens
    if (!taken) begin
      mode_nxt = M_IDLE;
      len_nxt  = 8'd1;
      if (is_digit(ch)) begin
        mode_nxt = M_INT;
      end else if (is_letter(ch)) begin
        mode_nxt = M_IDENT;
        wr_en    = 1'b1;
        wr_idx   = '0;
      end else begin
        case (ch) inside
          CH_SP, CH_TAB: i_emit = 1'b0;
          CH_NL:  if (line_r != 16'hFFFF) line_nxt = line_r + 16'd1;
          CH_EOT: begin i_emit = 1'b1; i_kind = K_END; i_len = 8'd0; end
          ".":    mode_nxt = M_DOT;
          "/":    mode_nxt = M_SLASH;
          "=":    mode_nxt = M_EQ;
          "!":    mode_nxt = M_BANG;
          "<":    mode_nxt = M_LESS;
          ">":    mode_nxt = M_MORE;
          "|":    mode_nxt = M_BAR;
          "&":    mode_nxt = M_AMP;
          ",":    begin i_emit = 1'b1; i_kind = K_COMMA;  end
          ";":    begin i_emit = 1'b1; i_kind = K_SEMI;   end
          ":":    begin i_emit = 1'b1; i_kind = K_COLON;  end
          "(":    begin i_emit = 1'b1; i_kind = K_LPAREN; end
          ")":    begin i_emit = 1'b1; i_kind = K_RPAREN; end
          "{":    begin i_emit = 1'b1; i_kind = K_LBRACE; end
          "}":    begin i_emit = 1'b1; i_kind = K_RBRACE; end
          "%":    begin i_emit = 1'b1; i_kind = K_PCT;    end
          "*":    begin i_emit = 1'b1; i_kind = K_STAR;   end
          "-":    begin i_emit = 1'b1; i_kind = K_MINUS;  end
          "+":    begin i_emit = 1'b1; i_kind = K_PLUS;   end
          default: begin i_emit = 1'b1; i_kind = K_ERR;   end
        endcase
      end
    end
  end

  // Build up to two result words; the last flag goes on the final one
  always_comb begin
    tok_p = '{kind: p_kind, length: p_len, line: line_r, last: !i_emit};
    tok_i = '{kind: i_kind, length: i_len, line: line_r, last: 1'b1};
    push.n    = take ? (2'(p_emit) + 2'(i_emit)) : 2'd0;
    push.tok0 = p_emit ? tok_p : tok_i;
    push.tok1 = tok_i;
  end

  // Advance scanner state on each accepted character
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      len_r  <= 8'd0;
      line_r <= 16'd0;
    end else if (take) begin
      mode_r <= mode_nxt;
      len_r  <= len_nxt;
      line_r <= line_nxt;
    end
  end

  // Keyword buffer holds no reset; only written positions are compared
  always_ff @(posedge clk) begin
    if (take && wr_en) word_r[wr_idx] <= ch;
  end

  a_line_only_on_nl: assert property (@(posedge clk) disable iff (!rst_n)
    !(take && (ch == CH_NL)) |=> $stable(line_r))
    else $error("line count changed without a newline");

  a_eot_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (take && (ch == CH_EOT)) |=> (mode_r == M_IDLE))
    else $error("end mark did not return scanner to idle");

  a_last_on_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n == 2'd2) |-> (!push.tok0.last && push.tok1.last))
    else $error("last flag misplaced on a two-word step");

endmodule

@@ hdl/stsc_queue.sv @@
module stsc_queue import stsc_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  push_t  push,
  output logic   full,
  output logic   out_valid,
  input  logic   out_stall,
  output token_t out_tok
);

  token_t              q_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_r, rd_r;
  logic [QCOUNT_W-1:0] count_r, count_nxt;
  logic                pop;

  assign out_valid = (count_r != '0);
  assign out_tok   = q_r[rd_r];
  assign pop       = out_valid && !out_stall;
  // stall the source unless two free entries remain
  assign full      = (count_r > QCOUNT_W'(QDEPTH - 2));
  assign count_nxt = count_r + QCOUNT_W'(push.n) - QCOUNT_W'(pop);

  // Store pushed words
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) q_r[wr_r] <= push.tok0;
    if (push.n == 2'd2) q_r[wr_r + QPTR_W'(1)] <= push.tok1;
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_r + QPTR_W'(push.n);
      if (pop) rd_r <= rd_r + QPTR_W'(1);
      count_r <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCOUNT_W'(QDEPTH))
    else $error("result queue count overflow");

  a_room_on_push: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n != 2'd0) |-> (count_r <= QCOUNT_W'(QDEPTH - 2)))
    else $error("push without room for two words");

  a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && (push.n == 2'd0)) |=> (count_r == $past(count_r) - QCOUNT_W'(1)))
    else $error("pop did not reduce count");

endmodule

@@ hdl/source_token_scanner_top.sv @@
// Channel  Direction  Handshake            Word
// in       sink       in_valid / in_stall   in_ch
// out      source     out_valid / out_stall out_token_kind, out_token_length,
//                                           out_line_number, out_last
// cfg      sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// One character is scanned per clock unless in_stall is high; its tokens pass
// through the registered result queue; two tokens from one character leave on out in turn.
// A four-word result queue sets the rate: in_stall rises while fewer than two
// entries are free, so input runs at one character per clock unless out stalls.
// Synchronous reset clears scanner state, line count and queue pointers, and sets the limits to their defaults.
// cfg_ready is always high; limits take effect on the next character.
module source_token_scanner_top import stsc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_ch,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_token_kind,
  output logic [7:0]  out_token_length,
  output logic [15:0] out_line_number,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  limits_t lim_r;
  push_t   push;
  token_t  out_tok;
  logic    take;
  logic    full;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign take      = in_valid && !in_stall;

  // Hold configuration limits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r.ident_limit <= 8'd32;
      lim_r.int_limit   <= 8'd10;
      lim_r.real_limit  <= 8'd20;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_IDENT_LIMIT: lim_r.ident_limit <= cfg_data;
        REG_INT_LIMIT:   lim_r.int_limit   <= cfg_data;
        REG_REAL_LIMIT:  lim_r.real_limit  <= cfg_data;
        default:         lim_r             <= lim_r;
      endcase
    end
  end

  stsc_scan u_scan (
    .clk  (clk),
    .rst_n(rst_n),
    .take (take),
    .ch   (in_ch),
    .lim  (lim_r),
    .push (push)
  );

  stsc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_tok  (out_tok)
  );

  assign out_token_kind   = out_tok.kind;
  assign out_token_length = out_tok.length;
  assign out_line_number  = out_tok.line;
  assign out_last         = out_tok.last;

endmodule
